/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VNF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VNF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define VNF_ASSERT_IMP(label, ante, cons)
`define VNF_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/core/vnf_pkg.sv */
// ---------------------------------------------------------------------------
// vnf_pkg
// types, hash constants and arithmetic helpers of the value-noise generator
// ---------------------------------------------------------------------------
package vnf_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic [15:0]        noise_t;
  typedef logic [31:0]        seed_t;
  typedef logic [3:0]         oct_cnt_t;
  typedef logic [3:0]         cfg_idx_t;
  typedef logic [31:0]        cfg_data_t;

  localparam cfg_idx_t REG_SEED      = 4'd0;
  localparam cfg_idx_t REG_OCT_COUNT = 4'd1;

  localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
  localparam logic [31:0] HASH_MUL_SEED = 32'd362437;
  localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;
  localparam logic [31:0] SEED_STEP     = 32'd17;

  localparam seed_t    SEED_RST      = 32'd0;
  localparam oct_cnt_t OCT_COUNT_RST = 4'd4;

  // smoothstep weight s = f*f*(3 - 2f) in q0.16, f2 already floored
  function automatic noise_t smooth16(input noise_t f2, input noise_t f);
    logic [17:0] t;
    logic [33:0] p;
    begin
      t = 18'd196608 - {1'b0, f, 1'b0};
      p = 34'(f2) * 34'(t);
      smooth16 = p[31:16];
    end
  endfunction

  function automatic noise_t lerp16(input noise_t p, input noise_t q, input noise_t s);
    logic [16:0] w;
    logic [33:0] v;
    begin
      w = 17'd65536 - 17'(s);
      v = 34'(p) * 34'(w) + 34'(q) * 34'(s);
      lerp16 = v[31:16];
    end
  endfunction

endpackage

/* rtl/core/vnf_if.sv */
// ---------------------------------------------------------------------------
// vnf_if
// valid/ready channels: sample input, noise result and register writes
// ---------------------------------------------------------------------------
interface vnf_in_if;
  import vnf_pkg::*;
  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vnf_out_if;
  import vnf_pkg::*;
  logic   valid;
  logic   ready;
  noise_t noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

interface vnf_cfg_if;
  import vnf_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/value_noise_fbm_generator_core.sv */
// ---------------------------------------------------------------------------
// value_noise_fbm_generator_core
// fractal value-noise height from a signed q16.16 sample point
// ---------------------------------------------------------------------------
// in_ch takes one sample point (x_coord, y_coord) per item; out_ch returns
// one q0.16 noise_value per item, in order. cfg_ch writes seed (index 0)
// and octave_count (index 1), ignores other indexes and is always ready.
// The user must write it only while idle; the core does not enforce it.
// Every octave has a lane of its own, so all octaves of one item are
// computed side by side through seven register stages: input capture,
// lattice split and hash products, hash mix and smoothstep, mix multiply,
// row blend, column blend, octave sum. Throughput is one item per cycle
// while out_ch does not stall, set by the pipeline, with no bubble
// between items.
// A stalled out_ch freezes the whole pipeline; in_ch.ready drops only
// while the last stage holds an item that is not taken.
// Reset empties the pipeline and sets seed to 0 and octave_count to 4.
// ---------------------------------------------------------------------------
module value_noise_fbm_generator_core #(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input logic      clk,
  input logic      rst_n,
  vnf_in_if.sink   in_ch,
  vnf_out_if.source out_ch,
  vnf_cfg_if.sink  cfg_ch
);
  import vnf_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int SUM_W  = 16 + CNT_W;
  localparam int NSTG   = 7;
  localparam int FSH_R  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int FSH_L  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [31:0] FMASK = 32'((64'd1 << FRAC_BITS) - 64'd1);

  seed_t    seed_r;
  oct_cnt_t oct_cnt_r;

  logic             vld_r [NSTG];
  logic [CNT_W-1:0] n_r   [NSTG];
  logic             adv;

  // stage 0
  coord_t x0_r, y0_r;
  seed_t  seed0_r;
  logic [CNT_W-1:0] n_sat;

  // stage 1..5 lane data
  logic [31:0] mx0_r [MAX_OCTAVES];
  logic [31:0] mx1_r [MAX_OCTAVES];
  logic [31:0] my0_r [MAX_OCTAVES];
  logic [31:0] my1_r [MAX_OCTAVES];
  logic [31:0] ms_r  [MAX_OCTAVES];
  noise_t      fx1_r [MAX_OCTAVES];
  noise_t      fy1_r [MAX_OCTAVES];
  noise_t      fxq_r [MAX_OCTAVES];
  noise_t      fyq_r [MAX_OCTAVES];
  logic [31:0] g_r   [MAX_OCTAVES][4];
  noise_t      sx2_r [MAX_OCTAVES];
  noise_t      sy2_r [MAX_OCTAVES];
  logic [31:0] m_r   [MAX_OCTAVES][4];
  noise_t      sx3_r [MAX_OCTAVES];
  noise_t      sy3_r [MAX_OCTAVES];
  noise_t      top_r [MAX_OCTAVES];
  noise_t      bot_r [MAX_OCTAVES];
  noise_t      sy4_r [MAX_OCTAVES];
  noise_t      v_r   [MAX_OCTAVES];
  noise_t      out_r;
  logic [SUM_W-1:0] sum_nxt;

  assign adv          = !vld_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = vld_r[NSTG-1];
  assign out_ch.noise_value = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= SEED_RST;
      oct_cnt_r <= OCT_COUNT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_SEED:      seed_r    <= cfg_ch.data;
        REG_OCT_COUNT: oct_cnt_r <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(oct_cnt_r) > 32'(MAX_OCTAVES)) n_sat = CNT_W'(MAX_OCTAVES);
    else n_sat = CNT_W'(oct_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < NSTG; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r    <= in_ch.x_coord;
      y0_r    <= in_ch.y_coord;
      seed0_r <= seed_r;
      n_r[0]  <= n_sat;
      for (int k = 1; k < NSTG; k++) n_r[k] <= n_r[k-1];
    end
  end

  // lane o works on the point shifted left by o with seed + 17*o
  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
    logic [31:0] xo, yo, xi, yi, fxm, fym;
    noise_t      fx, fy;
    logic [31:0] fxx, fyy;
    logic [31:0] h [4];

    always_comb begin
      xo  = 32'(x0_r) << o;
      yo  = 32'(y0_r) << o;
      xi  = 32'($signed(xo) >>> FRAC_BITS);
      yi  = 32'($signed(yo) >>> FRAC_BITS);
      fxm = xo & FMASK;
      fym = yo & FMASK;
      if (FRAC_BITS >= 16) begin
        fx = 16'(fxm >> FSH_R);
        fy = 16'(fym >> FSH_R);
      end else begin
        fx = 16'(fxm << FSH_L);
        fy = 16'(fym << FSH_L);
      end
      fxx = 32'(fx) * 32'(fx);
      fyy = 32'(fy) * 32'(fy);
      // corners a, b, c, d: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
      h[0] = mx0_r[o] + my0_r[o] + ms_r[o];
      h[1] = mx1_r[o] + my0_r[o] + ms_r[o];
      h[2] = mx0_r[o] + my1_r[o] + ms_r[o];
      h[3] = mx1_r[o] + my1_r[o] + ms_r[o];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mx0_r[o] <= xi * HASH_MUL_X;
        mx1_r[o] <= (xi + 32'd1) * HASH_MUL_X;
        my0_r[o] <= yi * HASH_MUL_Y;
        my1_r[o] <= (yi + 32'd1) * HASH_MUL_Y;
        ms_r[o]  <= (seed0_r + 32'(o) * SEED_STEP) * HASH_MUL_SEED;
        fx1_r[o] <= fx;
        fy1_r[o] <= fy;
        fxq_r[o] <= fxx[31:16];
        fyq_r[o] <= fyy[31:16];
        for (int c = 0; c < 4; c++) begin
          g_r[o][c] <= h[c] ^ (h[c] >> 13);
          m_r[o][c] <= g_r[o][c] * HASH_MUL_MIX;
        end
        sx2_r[o] <= smooth16(fxq_r[o], fx1_r[o]);
        sy2_r[o] <= smooth16(fyq_r[o], fy1_r[o]);
        sx3_r[o] <= sx2_r[o];
        sy3_r[o] <= sy2_r[o];
        // top half of h ^ (h >> 16) is just the top half of the product
        top_r[o] <= lerp16(m_r[o][0][31:16], m_r[o][1][31:16], sx3_r[o]);
        bot_r[o] <= lerp16(m_r[o][2][31:16], m_r[o][3][31:16], sx3_r[o]);
        sy4_r[o] <= sy3_r[o];
        v_r[o]   <= lerp16(top_r[o], bot_r[o], sy4_r[o]);
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int o = 0; o < MAX_OCTAVES; o++) begin
      if (32'(o) < 32'(n_r[NSTG-2])) sum_nxt = sum_nxt + SUM_W'(v_r[o] >> (o + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= (sum_nxt > SUM_W'(16'hFFFF)) ? 16'hFFFF : sum_nxt[15:0];
    end
  end

  `VNF_ASSERT_IMP(a_cnt_sat, vld_r[0], 32'(n_r[0]) <= 32'(MAX_OCTAVES))
  `VNF_ASSERT_IMP(a_sum_fits, vld_r[NSTG-2], sum_nxt <= SUM_W'(16'hFFFF))
  `VNF_ASSERT_NXT(a_stall_hold, vld_r[NSTG-1] && !out_ch.ready, vld_r[NSTG-1] && $stable(out_r))
  `VNF_ASSERT_IMP(a_ready_adv, vld_r[NSTG-1] && !out_ch.ready, !in_ch.ready)

endmodule
